/* sv/buddy_pkg.sv */
// shared constants and codes for the buddy allocator
package buddy_pkg;

    localparam int ADDR_OUT_W = 10;
    localparam int SIZE_W     = 11;
    localparam int OWNER_IN_W = 16;
    localparam int CFG_W      = 4;
    localparam int K_W        = 4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

endpackage

/* sv/buddy_allocator.sv */
// buddy allocator top level: block table memories and scan/split/merge sequencer
//
// channel   direction  signals                                       transfer
// -------   ---------  --------------------------------------------  ---------------------
// request   in         i_start, i_action, i_request_size, i_owner_id i_start & !o_busy
// result    out        o_valid, o_ok, o_start_address, o_end_address one cycle on o_valid
// config    in         i_cfg_we, i_cfg_wdata (pool order)            i_cfg_we
//
// an allocation whose result is known at once (zero size, too large) is answered from idle;
// otherwise the address-ordered scan reads and then checks each block it visits (one table
// memory read port); a grant then splits the block as needed and marks it used, a release
// reads and checks each buddy and then writes the merged header, a miss adds nothing
// a release result shows right after the scan; merging goes on with o_busy high
// after reset and after each config write a clearing pass over all 2^MAX_ORDER table
// entries rebuilds the table as one free block; o_busy is high during it
// the receiver cannot stall: each result is shown for exactly one cycle
module buddy_allocator #(
    parameter int MAX_ORDER  = 10,
    parameter int OWNER_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_action,
    input  logic [buddy_pkg::SIZE_W-1:0]      i_request_size,
    input  logic [buddy_pkg::OWNER_IN_W-1:0]  i_owner_id,
    input  logic                              i_cfg_we,
    input  logic [buddy_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                              o_valid,
    output logic                              o_ok,
    output logic [buddy_pkg::ADDR_OUT_W-1:0]  o_start_address,
    output logic [buddy_pkg::ADDR_OUT_W-1:0]  o_end_address
);
    import buddy_pkg::*;

    localparam int AW    = MAX_ORDER;           // unit address bits
    localparam int PW    = MAX_ORDER + 1;       // can hold the pool size itself
    localparam int OW    = $clog2(MAX_ORDER + 1);
    localparam int DEPTH = 1 << MAX_ORDER;
    localparam int RST_ORDER = (MAX_ORDER < 10) ? MAX_ORDER : 10;

    // per-unit block header, meaningful at block starts only
    typedef struct packed {
        logic          start;
        logic          used;
        logic [OW-1:0] order;
    } t_meta;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_A_RD, ST_A_CHK, ST_A_SPLIT,
        ST_F_RD, ST_F_CHK, ST_M_RD, ST_M_CHK, ST_M_FIN
    } t_state;

    // block table memories
    t_meta                 r_meta_mem [DEPTH];
    logic [OWNER_BITS-1:0] r_own_mem  [DEPTH];
    t_meta                 r_meta_q;
    logic [OWNER_BITS-1:0] r_own_q;

    t_state                r_state, n_state;
    logic [OW-1:0]         r_pool_order, n_pool_order;
    logic [AW-1:0]         r_clr, n_clr;
    logic [PW-1:0]         r_u, n_u;            // scan position
    logic [AW-1:0]         r_s, n_s;            // merging block start
    logic [OW-1:0]         r_ord, n_ord;
    logic [K_W-1:0]        r_k, n_k;
    logic [OWNER_BITS-1:0] r_owner, n_owner;
    logic                  r_valid, n_valid;
    logic                  r_ok, n_ok;
    logic [ADDR_OUT_W-1:0] r_sa, n_sa, r_ea, n_ea;

    logic                  w_we, w_own_we;
    logic [AW-1:0]         w_wa, w_ra;
    t_meta                 w_wd;

    logic                  w_accept;
    logic [K_W-1:0]        w_k;
    logic [SIZE_W-1:0]     w_size_m1;
    logic [PW-1:0]         w_pool, w_blk, w_next_u;
    logic [AW-1:0]         w_bbit, w_buddy;
    logic                  w_last;

    assign w_accept  = i_start && (r_state == ST_IDLE);
    assign w_size_m1 = i_request_size - SIZE_W'(1);

    // size rounded up to a power of two: bit length of size - 1
    always_comb begin
        w_k = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (w_size_m1[i]) begin
                w_k = K_W'(i + 1);
            end
        end
    end

    assign w_pool   = PW'(1) << r_pool_order;
    assign w_blk    = PW'(1) << r_meta_q.order;
    assign w_next_u = r_u + w_blk;
    assign w_last   = (w_next_u >= w_pool);
    assign w_bbit   = AW'(1) << r_ord;
    assign w_buddy  = r_s ^ w_bbit;
    assign w_ra     = (r_state == ST_M_RD) ? w_buddy : r_u[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_pool_order = r_pool_order;
        n_clr        = r_clr;
        n_u          = r_u;
        n_s          = r_s;
        n_ord        = r_ord;
        n_k          = r_k;
        n_owner      = r_owner;
        n_valid      = 1'b0;
        n_ok         = r_ok;
        n_sa         = r_sa;
        n_ea         = r_ea;
        w_we         = 1'b0;
        w_own_we     = 1'b0;
        w_wa         = r_u[AW-1:0];
        w_wd         = '0;

        case (r_state)
            ST_CLEAR: begin
                // sweep the table; unit zero becomes the one free block
                w_we = 1'b1;
                w_wa = r_clr;
                if (r_clr == '0) begin
                    w_wd = '{start: 1'b1, used: 1'b0, order: r_pool_order};
                end
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_u     = '0;
                    n_k     = w_k;
                    n_owner = OWNER_BITS'(i_owner_id);
                    n_sa    = '0;
                    n_ea    = '0;
                    if (i_action == ACT_FREE) begin
                        n_state = ST_F_RD;
                    end else if (i_request_size == '0) begin
                        n_valid = 1'b1;
                        n_ok    = 1'b1;
                    end else if (32'(w_k) > 32'(r_pool_order)) begin
                        n_valid = 1'b1;
                        n_ok    = 1'b0;
                    end else begin
                        n_state = ST_A_RD;
                    end
                end
            end
            ST_A_RD: n_state = ST_A_CHK;
            ST_A_CHK: begin
                if (!r_meta_q.used && (32'(r_meta_q.order) >= 32'(r_k))) begin
                    n_ord   = r_meta_q.order;
                    n_state = ST_A_SPLIT;
                end else if (w_last) begin
                    n_valid = 1'b1;
                    n_ok    = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    n_u     = w_next_u;
                    n_state = ST_A_RD;
                end
            end
            ST_A_SPLIT: begin
                w_we = 1'b1;
                if (32'(r_ord) > 32'(r_k)) begin
                    // keep the lower half, upper half becomes a free block
                    n_ord = r_ord - OW'(1);
                    w_wa  = r_u[AW-1:0] + (AW'(1) << n_ord);
                    w_wd  = '{start: 1'b1, used: 1'b0, order: n_ord};
                end else begin
                    w_wa     = r_u[AW-1:0];
                    w_wd     = '{start: 1'b1, used: 1'b1, order: OW'(r_k)};
                    w_own_we = 1'b1;
                    n_valid  = 1'b1;
                    n_ok     = 1'b1;
                    n_sa     = ADDR_OUT_W'(r_u);
                    n_ea     = ADDR_OUT_W'(r_u + (PW'(1) << r_k) - PW'(1));
                    n_state  = ST_IDLE;
                end
            end
            ST_F_RD: n_state = ST_F_CHK;
            ST_F_CHK: begin
                if (r_meta_q.used && (r_own_q == r_owner)) begin
                    n_valid = 1'b1;
                    n_ok    = 1'b1;
                    n_sa    = ADDR_OUT_W'(r_u);
                    n_ea    = ADDR_OUT_W'(w_next_u - PW'(1));
                    n_s     = r_u[AW-1:0];
                    n_ord   = r_meta_q.order;
                    n_state = (r_meta_q.order < r_pool_order) ? ST_M_RD : ST_M_FIN;
                end else if (w_last) begin
                    n_valid = 1'b1;
                    n_ok    = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    n_u     = w_next_u;
                    n_state = ST_F_RD;
                end
            end
            ST_M_RD: n_state = ST_M_CHK;
            ST_M_CHK: begin
                if (r_meta_q.start && (r_meta_q.order == r_ord) && !r_meta_q.used) begin
                    // upper of the pair stops being a block start
                    w_we    = 1'b1;
                    w_wa    = r_s | w_bbit;
                    w_wd    = '0;
                    n_s     = r_s & ~w_bbit;
                    n_ord   = r_ord + OW'(1);
                    n_state = (n_ord < r_pool_order) ? ST_M_RD : ST_M_FIN;
                end else begin
                    n_state = ST_M_FIN;
                end
            end
            ST_M_FIN: begin
                w_we    = 1'b1;
                w_wa    = r_s;
                w_wd    = '{start: 1'b1, used: 1'b0, order: r_ord};
                n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase

        // pool re-initialization always wins
        if (i_cfg_we) begin
            n_pool_order = (32'(i_cfg_wdata) > MAX_ORDER) ? OW'(MAX_ORDER)
                                                           : OW'(i_cfg_wdata);
            n_clr   = '0;
            n_valid = 1'b0;
            n_state = ST_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_pool_order <= OW'(RST_ORDER);
            r_clr        <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pool_order <= n_pool_order;
            r_clr        <= n_clr;
            r_valid      <= n_valid;
        end
        r_u     <= n_u;
        r_s     <= n_s;
        r_ord   <= n_ord;
        r_k     <= n_k;
        r_owner <= n_owner;
        r_ok    <= n_ok;
        r_sa    <= n_sa;
        r_ea    <= n_ea;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_meta_mem[w_wa] <= w_wd;
        end
        r_meta_q <= r_meta_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_own_we) begin
            r_own_mem[w_wa] <= r_owner;
        end
        r_own_q <= r_own_mem[w_ra];
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_ok            = r_ok;
    assign o_start_address = r_sa;
    assign o_end_address   = r_ea;

    // failed transactions report an empty range
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> (o_start_address == '0) && (o_end_address == '0))
        else $error("failed result with nonzero range");

    // a granted or released block never ends before it starts
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ok |-> o_end_address >= o_start_address)
        else $error("result range reversed");

    // splitting and merging stay within the pool order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_A_SPLIT) || (r_state == ST_M_FIN) |-> r_ord <= r_pool_order)
        else $error("block order beyond pool order");

    // a free request always goes through the scan
    a_free_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_action == ACT_FREE) && !i_cfg_we |=> o_busy && !o_valid)
        else $error("free request finished without scanning");

endmodule
